>>> hdl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam logic [11:0] MAX_CAPACITY  = 12'd4095;
    localparam logic [11:0] CAP_RESET     = 12'd36;

    localparam logic [15:0] UNIT_REPLACE  = 16'hFFFD;
    localparam logic [15:0] SURR_HIGH     = 16'hD800;
    localparam logic [15:0] SURR_LOW      = 16'hDC00;
    localparam logic [15:0] SURR_OFFSET   = 16'h0040;
    localparam logic [20:0] SUPPLEMENTARY = 21'h10000;

    localparam logic [7:0]  MASK_TOP2     = 8'hC0;
    localparam logic [7:0]  MASK_TOP3     = 8'hE0;
    localparam logic [7:0]  MASK_TOP4     = 8'hF0;
    localparam logic [7:0]  MASK_TOP5     = 8'hF8;
    localparam logic [7:0]  MARK_CONT     = 8'h80;
    localparam logic [7:0]  MARK_LEAD2    = 8'hC0;
    localparam logic [7:0]  MARK_LEAD3    = 8'hE0;
    localparam logic [7:0]  MARK_LEAD4    = 8'hF0;
    localparam logic [7:0]  MASK_PAYLOAD  = 8'h3F;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        string_end;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

>>> hdl/u8u16_decode.sv
`timescale 1ns / 1ps

module u8u16_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic [11:0]        i_capacity,
    output u8u16_pkg::t_push   o_push
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_pending, n_pending;
    logic        r_invalid, n_invalid;
    logic [11:0] r_written, n_written;

    logic [11:0] cap;
    logic        lead;
    logic        rep;
    logic        done;
    logic [12:0] written1;
    logic [20:0] cp;
    logic [15:0] high_unit;
    logic [15:0] low_unit;
    u8u16_pkg::t_result rep_res;
    u8u16_pkg::t_result chr0_res;
    u8u16_pkg::t_result chr1_res;

    always_comb begin
        cap = (i_capacity > u8u16_pkg::MAX_CAPACITY) ? u8u16_pkg::MAX_CAPACITY : i_capacity;
        lead = (i_byte & u8u16_pkg::MASK_TOP2) != u8u16_pkg::MARK_CONT;
        rep = lead && ((r_pending != 2'd0) || r_invalid);
        written1 = {1'b0, r_written} + {12'd0, rep};

        n_partial = r_partial;
        n_pending = r_pending;
        n_invalid = r_invalid;
        n_written = r_written;
        done = 1'b0;
        cp = 21'd0;
        o_push = '0;

        if (lead) begin
            n_invalid = 1'b0;
            if ((i_byte & u8u16_pkg::MASK_TOP5) == u8u16_pkg::MARK_LEAD4) begin
                n_partial = {18'd0, i_byte[2:0]};
                n_pending = 2'd3;
            end else if ((i_byte & u8u16_pkg::MASK_TOP4) == u8u16_pkg::MARK_LEAD3) begin
                n_partial = {17'd0, i_byte[3:0]};
                n_pending = 2'd2;
            end else if ((i_byte & u8u16_pkg::MASK_TOP3) == u8u16_pkg::MARK_LEAD2) begin
                n_partial = {16'd0, i_byte[4:0]};
                n_pending = 2'd1;
            end else begin
                n_partial = {14'd0, i_byte[6:0]};
                n_pending = 2'd0;
                done = 1'b1;
            end
        end else if (!r_invalid) begin
            if (r_pending != 2'd0) begin
                n_partial = {r_partial[14:0], 6'd0}
                          + {15'd0, i_byte[5:0] & u8u16_pkg::MASK_PAYLOAD[5:0]};
                n_pending = r_pending - 2'd1;
                done = (n_pending == 2'd0);
            end else begin
                n_invalid = 1'b1;
            end
        end

        cp = n_partial;
        high_unit = u8u16_pkg::SURR_HIGH | ({5'd0, cp[20:10]} - u8u16_pkg::SURR_OFFSET);
        low_unit = u8u16_pkg::SURR_LOW | {6'd0, cp[9:0]};

        rep_res = '{code_unit: u8u16_pkg::UNIT_REPLACE, unit_present: 1'b1,
                    string_end: 1'b0, last_of_run: 1'b0};
        chr0_res = '{code_unit: 16'd0, unit_present: 1'b1,
                     string_end: 1'b0, last_of_run: 1'b0};
        chr1_res = '{code_unit: low_unit, unit_present: 1'b1,
                     string_end: 1'b0, last_of_run: 1'b1};

        if (i_byte == 8'd0) begin
            o_push.count = 2'd1;
            o_push.first.string_end = 1'b1;
            o_push.first.last_of_run = 1'b1;
            if (((r_pending != 2'd0) || r_invalid) && (r_written < cap)) begin
                o_push.first.code_unit = u8u16_pkg::UNIT_REPLACE;
                o_push.first.unit_present = 1'b1;
            end
            n_partial = 21'd0;
            n_pending = 2'd0;
            n_invalid = 1'b0;
            n_written = 12'd0;
        end else if (r_written >= cap) begin
            n_partial = r_partial;
            n_pending = r_pending;
            n_invalid = r_invalid;
        end else begin
            // emit replacement first, then the completed character; a surrogate pair goes out without the replacement
            if (done && (written1 < {1'b0, cap})) begin
                if ((cp >= u8u16_pkg::SUPPLEMENTARY) && ((written1 + 13'd1) < {1'b0, cap})) begin
                    chr0_res.code_unit = high_unit;
                    o_push.count = 2'd2;
                    o_push.first = chr0_res;
                    o_push.second = chr1_res;
                    n_written = written1[11:0] + 12'd2;
                end else begin
                    chr0_res.code_unit = (cp >= u8u16_pkg::SUPPLEMENTARY) ? 16'd0 : cp[15:0];
                    chr0_res.last_of_run = 1'b1;
                    if (rep) begin
                        o_push.count = 2'd2;
                        o_push.first = rep_res;
                        o_push.second = chr0_res;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.first = chr0_res;
                    end
                    n_written = written1[11:0] + 12'd1;
                end
            end else if (rep) begin
                rep_res.last_of_run = 1'b1;
                o_push.count = 2'd1;
                o_push.first = rep_res;
                n_written = written1[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 21'd0;
            r_pending <= 2'd0;
            r_invalid <= 1'b0;
            r_written <= 12'd0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_invalid <= n_invalid;
            r_written <= n_written;
        end
    end

endmodule

>>> hdl/u8u16_outq.sv
`timescale 1ns / 1ps

module u8u16_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8u16_pkg::t_push    i_data,
    input  logic                i_out_stall,
    output logic                o_room,
    output logic                o_out_valid,
    output u8u16_pkg::t_result  o_head
);

    u8u16_pkg::t_result r_q0, n_q0;
    u8u16_pkg::t_result r_q1, n_q1;
    logic [1:0]         r_cnt, n_cnt;
    logic               pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_head = r_q0;
    assign pop = o_out_valid && !i_out_stall;
    assign o_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        n_cnt = r_cnt;
        if (i_push) begin
            n_q0 = i_data.first;
            n_q1 = i_data.second;
            n_cnt = i_data.count;
        end else if (pop) begin
            n_q0 = r_q1;
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop)))
        else $error("push without room for two results");

    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && (i_data.count == 2'd2)) |=> (r_cnt == 2'd2))
        else $error("result pair not stored");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_q0)))
        else $error("stalled head result changed");

endmodule

>>> hdl/utf8_to_utf16_converter.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 converter.
// Input channel: i_in_valid / o_in_stall with i_in_byte, one byte per transfer.
// A zero byte ends the string; it always yields exactly one o_string_end result
// (0xFFFD for an open or stray sequence below capacity, else a bare marker).
// Output channel: o_out_valid / i_out_stall with o_code_unit, o_unit_present,
// o_string_end and o_last_of_run; one result per transfer.
// Configuration: i_cfg_we / i_cfg_data writes the capacity in code units per
// string; write only while the block is idle.
// A byte's first result is registered and heads the output the next cycle.
// Throughput: one byte per cycle when each byte gives at most one result and
// the receiver does not stall; a byte that gives two results (surrogate pair,
// or replacement plus character) holds the input while the two-entry result
// queue drains.
// Reset: synchronous, active low; clears the string state and the queue and
// sets the capacity to 36.
// Receiver stall: the head result holds; the input stalls as soon as the
// queue cannot take two more results.

module utf8_to_utf16_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic        o_unit_present,
    output logic        o_string_end,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data
);

    logic [11:0]        r_capacity;
    logic               room;
    logic               accept;
    u8u16_pkg::t_push   push;
    u8u16_pkg::t_result head;

    assign o_in_stall = !room;
    assign accept = i_in_valid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= u8u16_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    u8u16_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in_byte),
        .i_capacity (r_capacity),
        .o_push     (push)
    );

    u8u16_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (push),
        .i_out_stall (i_out_stall),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_head      (head)
    );

    assign o_code_unit    = head.code_unit;
    assign o_unit_present = head.unit_present;
    assign o_string_end   = head.string_end;
    assign o_last_of_run  = head.last_of_run;

endmodule
